@@ rtl/core/scsl_pkg.sv @@
// Package for the shortest common supersequence length block.
// Holds the operation codes, the control bundle passed along the cell chain,
// and default sizes. No dependencies.
package scsl_pkg;

  // Default capacity of each string, in symbols.
  localparam int unsigned MaxLenDef = 32;

  // Field widths fixed by the stream format.
  localparam int unsigned SymW = 8;
  localparam int unsigned OpW  = 2;
  localparam int unsigned ScsW = 7;
  localparam int unsigned LcsW = 6;

  // Operation carried in tuser. The remaining code is ignored by the block.
  typedef enum logic [OpW-1:0] {
    OP_LOAD   = 2'd0,
    OP_SECOND = 2'd1,
    OP_FINISH = 2'd2
  } op_e;

  // Control bundle that moves from one cell to the next every cycle.
  typedef struct packed {
    logic vld;  // a second-string symbol is moving through this slot
    logic tok;  // the finish token is moving through this slot
  } scsl_ctl_t;

endpackage

@@ rtl/core/scsl_cell.sv @@
// One cell of the LCS chain: holds one first-string symbol and one LCS entry.
// Depends on scsl_pkg for the control bundle and the symbol width.
module scsl_cell
  import scsl_pkg::*;
#(
  parameter int unsigned VW = 6
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_en_i,
  input  logic [SymW-1:0] load_sym_i,
  input  logic            is_last_i,
  input  scsl_ctl_t       ctl_i,
  input  logic [SymW-1:0] sym_i,
  input  logic [VW-1:0]   up_i,
  input  logic [VW-1:0]   diag_i,
  input  logic [VW-1:0]   res_i,
  output scsl_ctl_t       ctl_o,
  output logic [SymW-1:0] sym_o,
  output logic [VW-1:0]   up_o,
  output logic [VW-1:0]   diag_o,
  output logic [VW-1:0]   res_o
);

  logic [SymW-1:0] first_sym_q;
  logic [VW-1:0]   lcs_q, lcs_d;
  logic [VW-1:0]   new_val;
  scsl_ctl_t       ctl_q;
  logic [SymW-1:0] sym_q;
  logic [VW-1:0]   up_q, up_d;
  logic [VW-1:0]   diag_q, diag_d;
  logic [VW-1:0]   res_q, res_d;

  // A match extends the diagonal; otherwise keep the larger neighbor.
  always_comb begin
    if (first_sym_q == sym_i) begin
      new_val = diag_i + VW'(1);
    end else if (lcs_q > up_i) begin
      new_val = lcs_q;
    end else begin
      new_val = up_i;
    end
  end

  always_comb begin
    lcs_d  = lcs_q;
    up_d   = up_i;
    diag_d = diag_i;
    res_d  = res_i;
    if (ctl_i.vld) begin
      lcs_d  = new_val;
      up_d   = new_val;
      diag_d = lcs_q;
    end
    if (ctl_i.tok) begin
      // The token trails every symbol, so this entry is final; then clear it.
      if (is_last_i) begin
        res_d = lcs_q;
      end
      lcs_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lcs_q <= '0;
      ctl_q <= '0;
    end else begin
      lcs_q <= lcs_d;
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_en_i) begin
      first_sym_q <= load_sym_i;
    end
    sym_q  <= sym_i;
    up_q   <= up_d;
    diag_q <= diag_d;
    res_q  <= res_d;
  end

  assign ctl_o  = ctl_q;
  assign sym_o  = sym_q;
  assign up_o   = up_q;
  assign diag_o = diag_q;
  assign res_o  = res_q;

endmodule

@@ rtl/core/shortest_common_supersequence_length_top.sv @@
// Top level of the shortest common supersequence length block.
// Depends on scsl_pkg and instantiates a chain of scsl_cell.
//
//   Channel   Direction  tdata (low bit first)                     tuser
//   s_axis    in         symbol[7:0]                               op[1:0]
//   m_axis    out        scs_length[6:0], lcs_length[12:7],        none
//                        error[13], zeros[15:14]
//
// A load, a second-string symbol or an ignored code is taken in a single
// transfer, and second-string symbols may arrive back to back: each one walks
// down the cell chain one cell per cycle, one step of the LCS row per cell. A
// finish sends a token down the same chain behind the last symbol; the result
// tvalid is registered when the token leaves the last cell. Input is held
// off from the finish transfer until the result transfer completes.
// Reset clears counts, flags and the LCS entries; stored symbols need no reset.
module shortest_common_supersequence_length_top
  import scsl_pkg::*;
#(
  parameter int unsigned MAX_LEN = MaxLenDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // symbol[7:0]
  input  logic [1:0]  s_axis_tuser_i,   // op[1:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o    // scs_length[6:0], lcs_length[12:7], error[13]
);

  // Counts and LCS values range from 0 to MAX_LEN.
  localparam int unsigned CW = $clog2(MAX_LEN + 1);
  localparam int unsigned SW = CW + 1;

  logic          in_xfer;
  logic          out_xfer;
  op_e           op;
  logic [CW-1:0] first_count_q, first_count_d;
  logic [CW-1:0] second_count_q, second_count_d;
  logic          started_q, started_d;
  logic          error_q, error_d;
  logic          busy_q, busy_d;
  logic [CW-1:0] m_q, m_d;
  logic [CW-1:0] n_q, n_d;
  logic          err_res_q, err_res_d;
  logic          out_vld_q, out_vld_d;
  logic [ScsW-1:0] scs_q, scs_d;
  logic [LcsW-1:0] lcs_q, lcs_d;
  logic [SW-1:0] scs_full;
  logic [CW-1:0] last_len;
  logic          first_full;
  logic          second_full;

  // Chain links: entry k feeds cell k, entry MAX_LEN leaves the last cell.
  scsl_ctl_t     ctl_link  [MAX_LEN+1];
  logic [SymW-1:0] sym_link [MAX_LEN+1];
  logic [CW-1:0] up_link   [MAX_LEN+1];
  logic [CW-1:0] diag_link [MAX_LEN+1];
  logic [CW-1:0] res_link  [MAX_LEN+1];
  logic          load_en   [MAX_LEN];
  logic          is_last   [MAX_LEN];

  assign s_axis_tready_o = !busy_q;
  assign in_xfer  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_xfer = m_axis_tvalid_o && m_axis_tready_i;
  assign op       = op_e'(s_axis_tuser_i);

  assign first_full  = (first_count_q >= CW'(MAX_LEN));
  assign second_full = (second_count_q >= CW'(MAX_LEN));

  // The token enters cell 0 in the finish cycle, before the length is captured.
  assign last_len = busy_q ? m_q : first_count_q;

  // Feed the head of the chain.
  assign ctl_link[0].vld = in_xfer && (op == OP_SECOND) && !second_full;
  assign ctl_link[0].tok = in_xfer && (op == OP_FINISH);
  assign sym_link[0]  = s_axis_tdata_i;
  assign up_link[0]   = '0;
  assign diag_link[0] = '0;
  assign res_link[0]  = '0;

  for (genvar i = 0; i < MAX_LEN; i++) begin : g_cell
    assign load_en[i] = in_xfer && (op == OP_LOAD) && !started_q && !first_full
                        && (first_count_q == CW'(i));
    assign is_last[i] = (last_len == CW'(i + 1));

    scsl_cell #(
      .VW (CW)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .load_en_i  (load_en[i]),
      .load_sym_i (s_axis_tdata_i),
      .is_last_i  (is_last[i]),
      .ctl_i      (ctl_link[i]),
      .sym_i      (sym_link[i]),
      .up_i       (up_link[i]),
      .diag_i     (diag_link[i]),
      .res_i      (res_link[i]),
      .ctl_o      (ctl_link[i+1]),
      .sym_o      (sym_link[i+1]),
      .up_o       (up_link[i+1]),
      .diag_o     (diag_link[i+1]),
      .res_o      (res_link[i+1])
    );
  end

  // The token leaving the last cell carries the final LCS value.
  assign scs_full = SW'(m_q) + SW'(n_q) - SW'(res_link[MAX_LEN]);

  always_comb begin
    first_count_d  = first_count_q;
    second_count_d = second_count_q;
    started_d      = started_q;
    error_d        = error_q;
    busy_d         = busy_q;
    m_d            = m_q;
    n_d            = n_q;
    err_res_d      = err_res_q;
    out_vld_d      = out_vld_q;
    scs_d          = scs_q;
    lcs_d          = lcs_q;

    if (in_xfer) begin
      unique case (op)
        OP_LOAD: begin
          if (started_q || first_full) begin
            error_d = 1'b1;
          end else begin
            first_count_d = first_count_q + CW'(1);
          end
        end
        OP_SECOND: begin
          started_d = 1'b1;
          if (second_full) begin
            error_d = 1'b1;
          end else begin
            second_count_d = second_count_q + CW'(1);
          end
        end
        OP_FINISH: begin
          m_d            = first_count_q;
          n_d            = second_count_q;
          err_res_d      = error_q;
          busy_d         = 1'b1;
          first_count_d  = '0;
          second_count_d = '0;
          started_d      = 1'b0;
          error_d        = 1'b0;
        end
        default: begin
          // The unused code is taken and dropped.
        end
      endcase
    end

    if (ctl_link[MAX_LEN].tok) begin
      out_vld_d = 1'b1;
      scs_d     = ScsW'(scs_full);
      lcs_d     = LcsW'(res_link[MAX_LEN]);
    end else if (out_xfer) begin
      out_vld_d = 1'b0;
      busy_d    = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_count_q  <= '0;
      second_count_q <= '0;
      started_q      <= 1'b0;
      error_q        <= 1'b0;
      busy_q         <= 1'b0;
      out_vld_q      <= 1'b0;
    end else begin
      first_count_q  <= first_count_d;
      second_count_q <= second_count_d;
      started_q      <= started_d;
      error_q        <= error_d;
      busy_q         <= busy_d;
      out_vld_q      <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_q       <= m_d;
    n_q       <= n_d;
    err_res_q <= err_res_d;
    scs_q     <= scs_d;
    lcs_q     <= lcs_d;
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {2'b00, err_res_q, lcs_q, scs_q};

endmodule
